/* src/hws_pkg.sv */
`default_nettype none

package hws_pkg;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 24;
    localparam int STEP_BITS      = 24;
    localparam int AMP_BITS       = 16;
    localparam int MAG_BITS       = 17;
    localparam int SAMPLE_BITS    = 16;
    localparam int PROD_BITS      = MAG_BITS + AMP_BITS;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [MAG_BITS-1:0]       mag_t;

    localparam cfg_index_t REG_WAVE_SHAPE   = 8'd0;
    localparam cfg_index_t REG_PHASE_STEP   = 8'd1;
    localparam cfg_index_t REG_AMPLITUDE    = 8'd2;
    localparam cfg_index_t REG_HARMONICS_ON = 8'd3;

    typedef enum logic [1:0] {
        SHAPE_SINE,
        SHAPE_SQUARE,
        SHAPE_TRIANGLE,
        SHAPE_SAWTOOTH
    } shape_t;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 24'd32768;
    localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET  = 16'd52429;

    localparam logic [14:0] GAIN_H3 = 15'd21627;
    localparam logic [14:0] GAIN_H5 = 15'd13107;

    localparam mag_t FULL_SCALE = 17'd32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic neg;
        mag_t mag;
    } shape_mag_t;

    // sin(x) for x in [0, pi/2] in Q30, result rounded to Q15
    function automatic mag_t sine_q15(input logic [63:0] x);
        logic [63:0] one;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        begin
            one = 64'd1 << 30;
            x2  = (x * x) >> 30;
            t   = one;
            t   = one - (((x2 * t) >> 30) / 64'd156);
            t   = one - (((x2 * t) >> 30) / 64'd110);
            t   = one - (((x2 * t) >> 30) / 64'd72);
            t   = one - (((x2 * t) >> 30) / 64'd42);
            t   = one - (((x2 * t) >> 30) / 64'd20);
            t   = one - (((x2 * t) >> 30) / 64'd6);
            r   = (x * t + (64'd1 << 44)) >> 45;
            if (r > 64'd32768)
            begin
                r = 64'd32768;
            end
            sine_q15 = r[MAG_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* src/hws_sine_rom.sv */
`default_nettype none

module hws_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [TABLE_BITS:0]   addr,
    output hws_pkg::mag_t              data
);

    localparam int TBL_N = 1 << TABLE_BITS;

    hws_pkg::mag_t rom [TBL_N+1];
    hws_pkg::mag_t data_reg;

    for (genvar k = 0; k <= TBL_N; k++)
    begin : g_tbl
        localparam logic [63:0] X_Q30 = (hws_pkg::HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
        assign rom[k] = hws_pkg::sine_q15(X_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* src/harmonic_waveform_synth_unit.sv */
`default_nettype none

// Harmonic waveform synthesizer.
// Sample channel: sample_index with sample_valid/sample_stall. Result channel:
// sample_value (signed Q1.15) and clipped with result_valid/result_stall.
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 wave_shape, 1 phase_step, 2 amplitude, 3 harmonics_on;
// other indexes are ignored. Write configuration only while the pipeline is empty.
// Throughput: one sample per cycle while no held result stalls the pipeline.
// A sample passes five register stages to result_valid (phase multiply, harmonic
// phases, sine table read and shape decode, amplitude multiply, sum and clamp).
// The sine table is a registered ROM per lane (fundamental, 3rd, 5th).
// Reset empties the pipeline and loads the default configuration: sine,
// phase_step 32768, amplitude 52429, harmonics off.
// When result_stall is high with a result waiting, the whole pipeline holds
// and sample_stall rises in the same cycle; nothing is dropped or repeated.

module harmonic_waveform_synth_unit #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int INDEX_BITS      = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire logic [INDEX_BITS-1:0]                sample_index,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed [hws_pkg::SAMPLE_BITS-1:0]    sample_value,
    output logic                                      clipped,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hws_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [hws_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PB    = PHASE_BITS;
    localparam int IB    = INDEX_BITS;
    localparam int STB   = SINE_TABLE_BITS;
    localparam int LANES = 3;
    localparam int MB    = hws_pkg::MAG_BITS;
    localparam int AB    = hws_pkg::AMP_BITS;
    localparam int PRB   = hws_pkg::PROD_BITS;
    localparam logic [PB-1:0]  HALF  = {1'b1, {(PB-1){1'b0}}};
    localparam logic [STB:0]   TBL_N = {1'b1, {STB{1'b0}}};

    // configuration
    hws_pkg::shape_t                   shape_reg;
    logic [hws_pkg::STEP_BITS-1:0]     phase_step_reg;
    logic [AB-1:0]                     amplitude_reg;
    logic                              harmonics_on_reg;
    logic [AB-1:0]                     g3_reg;
    logic [AB-1:0]                     g5_reg;
    logic [31:0]                       g3_full;
    logic [31:0]                       g5_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg        <= hws_pkg::SHAPE_SINE;
            phase_step_reg   <= hws_pkg::PHASE_STEP_RESET;
            amplitude_reg    <= hws_pkg::AMPLITUDE_RESET;
            harmonics_on_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hws_pkg::REG_WAVE_SHAPE:   shape_reg <= hws_pkg::shape_t'(cfg_data[1:0]);
                hws_pkg::REG_PHASE_STEP:   phase_step_reg <= cfg_data;
                hws_pkg::REG_AMPLITUDE:    amplitude_reg <= cfg_data[AB-1:0];
                hws_pkg::REG_HARMONICS_ON: harmonics_on_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    assign g3_full = 32'(amplitude_reg) * 32'(hws_pkg::GAIN_H3) + 32'd32768;
    assign g5_full = 32'(amplitude_reg) * 32'(hws_pkg::GAIN_H5) + 32'd32768;

    always_ff @(posedge clk)
    begin
        g3_reg <= g3_full[31:16];
        g5_reg <= g5_full[31:16];
    end

    // pipeline control
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign en           = !(v5_reg && result_stall);
    assign sample_stall = !en;
    assign result_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sample_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: base phase
    logic [31:0]        step_wide;
    logic [PB-1:0]      step;
    logic [PB+IB-1:0]   phase_prod;
    logic [PB-1:0]      p1_reg;

    assign step_wide  = {{(32-hws_pkg::STEP_BITS){1'b0}}, phase_step_reg};
    assign step       = step_wide[PB-1:0];
    assign phase_prod = {{PB{1'b0}}, sample_index} * {{IB{1'b0}}, step};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= phase_prod[PB-1:0];
        end
    end

    // stage 2: harmonic phases
    logic [PB-1:0] ph_next [LANES];
    logic [PB-1:0] ph_reg  [LANES];

    assign ph_next[0] = p1_reg;
    assign ph_next[1] = (p1_reg << 1) + p1_reg;
    assign ph_next[2] = (p1_reg << 2) + p1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= ph_next;
        end
    end

    // stages 3 and 4 per lane
    hws_pkg::mag_t       rom_q      [LANES];
    logic                sin_neg_reg [LANES];
    hws_pkg::shape_mag_t alt_reg    [LANES];
    logic [PRB-1:0]      prod_reg   [LANES];
    logic                neg4_reg   [LANES];
    logic [AB-1:0]       gain       [LANES];
    logic signed [MB+1:0] term      [LANES];

    assign gain[0] = amplitude_reg;
    assign gain[1] = g3_reg;
    assign gain[2] = g5_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [1:0]           quad;
        logic [STB-1:0]       tidx;
        logic [STB:0]         addr;
        logic [PB-1:0]        tri_d;
        logic [PB+MB-1:0]     tri_w;
        logic [MB-1:0]        tri_v;
        logic [15:0]          saw_v;
        hws_pkg::shape_mag_t  alt_next;
        hws_pkg::shape_mag_t  sel;
        logic [MB-1:0]        r;

        assign quad = ph_reg[l][PB-1 -: 2];
        assign tidx = ph_reg[l][PB-3 -: STB];
        assign addr = quad[0] ? (TBL_N - {1'b0, tidx}) : {1'b0, tidx};

        hws_sine_rom #(
            .TABLE_BITS(STB)
        ) u_rom (
            .clk  (clk),
            .en   (en),
            .addr (addr),
            .data (rom_q[l])
        );

        assign tri_d = ph_reg[l][PB-1] ? (ph_reg[l] - HALF) : (HALF - ph_reg[l]);
        assign tri_w = {tri_d, {MB{1'b0}}} >> PB;
        assign tri_v = tri_w[MB-1:0];
        assign saw_v = ph_reg[l][PB-1 -: 16];

        always_comb
        begin
            alt_next = '0;
            case (shape_reg)
                hws_pkg::SHAPE_SQUARE:
                begin
                    alt_next.neg = ph_reg[l][PB-1];
                    alt_next.mag = hws_pkg::FULL_SCALE;
                end
                hws_pkg::SHAPE_TRIANGLE:
                begin
                    alt_next.neg = (tri_v[MB-1:MB-2] == 2'b00);
                    alt_next.mag = alt_next.neg ? (hws_pkg::FULL_SCALE - tri_v)
                                                : (tri_v - hws_pkg::FULL_SCALE);
                end
                hws_pkg::SHAPE_SAWTOOTH:
                begin
                    alt_next.neg = !saw_v[15];
                    alt_next.mag = saw_v[15] ? {2'b00, saw_v[14:0]}
                                             : (hws_pkg::FULL_SCALE - {1'b0, saw_v});
                end
                default:
                begin
                    alt_next = '0;
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sin_neg_reg[l] <= quad[1];
                alt_reg[l]     <= alt_next;
            end
        end

        always_comb
        begin
            if (shape_reg == hws_pkg::SHAPE_SINE)
            begin
                sel.neg = sin_neg_reg[l];
                sel.mag = rom_q[l];
            end
            else
            begin
                sel = alt_reg[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[l] <= sel.mag * gain[l];
                neg4_reg[l] <= sel.neg;
            end
        end

        assign r       = prod_reg[l][PRB-1 -: MB];
        assign term[l] = neg4_reg[l] ? -$signed({2'b00, r}) : $signed({2'b00, r});
    end

    // stage 5: sum, clamp and saturate
    logic signed [MB+2:0]              sum;
    logic signed [MB+2:0]              harm_sum;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] value_next;
    logic                              clip_next;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] value_reg;
    logic                              clip_reg;

    assign harm_sum = harmonics_on_reg ? ((MB+3)'(term[1]) + (MB+3)'(term[2])) : '0;
    assign sum      = (MB+3)'(term[0]) + harm_sum;

    always_comb
    begin
        clip_next  = 1'b0;
        value_next = sum[hws_pkg::SAMPLE_BITS-1:0];
        if (sum >= (MB+3)'(signed'(32768)))
        begin
            value_next = 16'sh7FFF;
            clip_next  = 1'b1;
        end
        else if (sum < -(MB+3)'(signed'(32768)))
        begin
            value_next = 16'sh8000;
            clip_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            clip_reg  <= clip_next;
        end
    end

    assign sample_value = value_reg;
    assign clipped      = clip_reg;

endmodule

`default_nettype wire

/* src/hws_checker.sv */
`default_nettype none

module hws_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               sample_valid,
    input wire logic               sample_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic signed [15:0] sample_value,
    input wire logic               clipped
);

    logic sample_xfer;

    assign sample_xfer = sample_valid && !sample_stall;

    a_stall_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("sample_stall does not track a held result");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped) |->
            (sample_value == 16'sh7FFF) || (sample_value == 16'sh8000))
        else $error("clipped result is not at a rail");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(sample_value) && $stable(clipped)))
        else $error("stalled result changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer ##1 !result_stall ##1 !result_stall ##1 !result_stall
            ##1 !result_stall |=> result_valid)
        else $error("result missing after five cycles");

endmodule

bind harmonic_waveform_synth_unit hws_checker u_hws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_value (sample_value),
    .clipped      (clipped)
);

`default_nettype wire

/* test/tb_harmonic_waveform_synth_unit.sv */
`default_nettype none

module tb_harmonic_waveform_synth_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SINE_ENTRIES = 1024;
    localparam int DRAIN_CYCLES = 10;
    localparam int CHUNK_ITEMS  = 50;
    localparam int CHUNKS       = 11;

    typedef struct packed {
        logic signed [hws_pkg::SAMPLE_BITS-1:0] value;
        logic                                   clip;
    } synth_sample_t;

    class waveform_scoreboard;
        bit [hws_pkg::MAG_BITS-1:0]  sine_rom [0:SINE_ENTRIES];
        hws_pkg::shape_t             shape;
        bit [hws_pkg::STEP_BITS-1:0] step;
        bit [hws_pkg::AMP_BITS-1:0]  amp;
        bit                          harm;
        synth_sample_t               expected_q[$];
        int                          error_count;
        int                          sample_count;
        int                          result_count;
        int                          clip_count;

        function new();
            for (int k = 0; k <= SINE_ENTRIES; k++)
            begin
                sine_rom[k] = sine_level((hws_pkg::HALF_PI_Q30 * 64'(k)) >> 10);
            end
            shape = hws_pkg::SHAPE_SINE;
            step  = hws_pkg::PHASE_STEP_RESET;
            amp   = hws_pkg::AMPLITUDE_RESET;
            harm  = 1'b0;
        endfunction

        // angle in Q30, sine rounded to Q15 by a six-term Horner series
        function bit [hws_pkg::MAG_BITS-1:0] sine_level(bit [63:0] x);
            bit [63:0] one;
            bit [63:0] x2;
            bit [63:0] t;
            bit [63:0] r;
            one = 64'd1 << 30;
            x2  = (x * x) >> 30;
            t   = one;
            for (int n = 6; n >= 1; n--)
            begin
                t = one - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
            end
            r = (x * t + (64'd1 << 44)) >> 45;
            if (r > 64'd32768)
            begin
                r = 64'd32768;
            end
            return r[hws_pkg::MAG_BITS-1:0];
        endfunction

        function void write_reg(hws_pkg::cfg_index_t idx,
                                logic [hws_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                hws_pkg::REG_WAVE_SHAPE:   shape = hws_pkg::shape_t'(data[1:0]);
                hws_pkg::REG_PHASE_STEP:   step  = data[hws_pkg::STEP_BITS-1:0];
                hws_pkg::REG_AMPLITUDE:    amp   = data[hws_pkg::AMP_BITS-1:0];
                hws_pkg::REG_HARMONICS_ON: harm  = data[0];
                default:                   ;
            endcase
        endfunction

        function int shape_level(bit [hws_pkg::STEP_BITS-1:0] p);
            bit [1:0]                    quad;
            bit [9:0]                    slot;
            bit [hws_pkg::STEP_BITS-1:0] tri_dist;
            int                          m;
            case (shape)
                hws_pkg::SHAPE_SINE:
                begin
                    quad = p[23:22];
                    slot = p[21:12];
                    m = quad[0] ? int'(sine_rom[SINE_ENTRIES - int'(slot)])
                                : int'(sine_rom[slot]);
                    return quad[1] ? -m : m;
                end
                hws_pkg::SHAPE_SQUARE:
                begin
                    return p[23] ? -32768 : 32768;
                end
                hws_pkg::SHAPE_TRIANGLE:
                begin
                    tri_dist = p[23] ? p - 24'h800000 : 24'h800000 - p;
                    return int'(tri_dist >> 7) - 32768;
                end
                default:
                begin
                    return int'(p[23:8]) - 32768;
                end
            endcase
        endfunction

        function int scale_by(int v, bit [hws_pkg::AMP_BITS-1:0] a);
            longint mag;
            longint r;
            mag = (v < 0) ? -longint'(v) : longint'(v);
            r   = (mag * longint'(a)) >>> 16;
            return (v < 0) ? -int'(r) : int'(r);
        endfunction

        function void note_sample(bit [15:0] idx);
            bit [39:0]                   prod;
            bit [hws_pkg::STEP_BITS-1:0] p;
            bit [hws_pkg::STEP_BITS-1:0] p3;
            bit [hws_pkg::STEP_BITS-1:0] p5;
            bit [31:0]                   g3;
            bit [31:0]                   g5;
            int                          sum;
            bit                          clip;
            synth_sample_t               exp_sample;
            prod = idx * step;
            p    = prod[hws_pkg::STEP_BITS-1:0];
            clip = 1'b0;
            sum  = scale_by(shape_level(p), amp);
            if (harm)
            begin
                g3 = (32'(amp) * 32'(hws_pkg::GAIN_H3) + 32'd32768) >> 16;
                g5 = (32'(amp) * 32'(hws_pkg::GAIN_H5) + 32'd32768) >> 16;
                p3 = p * 24'd3;
                p5 = p * 24'd5;
                sum += scale_by(shape_level(p3), g3[hws_pkg::AMP_BITS-1:0]);
                sum += scale_by(shape_level(p5), g5[hws_pkg::AMP_BITS-1:0]);
                if (sum > 32768)
                begin
                    sum  = 32768;
                    clip = 1'b1;
                end
                if (sum < -32768)
                begin
                    sum  = -32768;
                    clip = 1'b1;
                end
            end
            if (sum > 32767)
            begin
                sum  = 32767;
                clip = 1'b1;
            end
            exp_sample.value = sum[hws_pkg::SAMPLE_BITS-1:0];
            exp_sample.clip  = clip;
            expected_q = {expected_q, exp_sample};
            sample_count++;
        endfunction

        function void check_result(logic signed [hws_pkg::SAMPLE_BITS-1:0] value, logic clip);
            synth_sample_t exp_sample;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual value %0d clipped %0b",
                         $time, value, clip);
                error_count++;
                return;
            end
            exp_sample = expected_q.pop_front();
            result_count++;
            if (exp_sample.clip)
            begin
                clip_count++;
            end
            if (value !== exp_sample.value)
            begin
                $display("%0t: sample_value mismatch, expected %0d, actual %0d",
                         $time, exp_sample.value, value);
                error_count++;
            end
            if (clip !== exp_sample.clip)
            begin
                $display("%0t: clipped mismatch, expected %0b, actual %0b",
                         $time, exp_sample.clip, clip);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n        = 1'b0;
    logic                                   sample_valid = 1'b0;
    logic                                   sample_stall;
    logic [15:0]                            sample_index = '0;
    logic                                   result_valid;
    logic                                   result_stall = 1'b0;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] sample_value;
    logic                                   clipped;
    logic                                   cfg_valid    = 1'b0;
    logic                                   cfg_ready;
    hws_pkg::cfg_index_t                    cfg_index    = '0;
    logic [hws_pkg::CFG_DATA_BITS-1:0]      cfg_data     = '0;

    waveform_scoreboard sb;
    int gap_pct   = 0;
    int stall_pct = 0;
    int settings_count = 0;

    harmonic_waveform_synth_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_index (sample_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_value (sample_value),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(sample_value, clipped);
        end
    end

    task automatic send_sample(input logic [15:0] idx);
        if ($urandom_range(99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        sample_valid <= 1'b1;
        sample_index <= idx;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(idx);
    endtask

    task automatic cfg_put(input hws_pkg::cfg_index_t idx,
                           input logic [hws_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // drain the pipeline, then load all four registers plus one unmapped index
    task automatic program_config(input hws_pkg::shape_t s,
                                  input logic [hws_pkg::STEP_BITS-1:0] st,
                                  input logic [hws_pkg::AMP_BITS-1:0] a, input logic h);
        logic [31:0] noise;
        noise = $urandom;
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        cfg_put(hws_pkg::cfg_index_t'($urandom_range(4, 255)),
                noise[hws_pkg::CFG_DATA_BITS-1:0]);
        cfg_put(hws_pkg::REG_WAVE_SHAPE, {noise[21:0], s});
        cfg_put(hws_pkg::REG_PHASE_STEP, st);
        cfg_put(hws_pkg::REG_AMPLITUDE, {noise[31:24], a});
        cfg_put(hws_pkg::REG_HARMONICS_ON, {noise[22:0], h});
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic run_directed();
        // reset values, no register write yet
        send_sample(16'd0);
        send_sample(16'd128);
        send_sample(16'd256);
        send_sample(16'd384);
        send_sample(16'hFFFF);
        // square at full amplitude with harmonics: clamp and saturation
        program_config(hws_pkg::SHAPE_SQUARE, 24'h400000, 16'hFFFF, 1'b1);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd2);
        send_sample(16'd3);
        program_config(hws_pkg::SHAPE_TRIANGLE, 24'hFFFFFF, 16'hFFFF, 1'b0);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        program_config(hws_pkg::SHAPE_SAWTOOTH, 24'd1, 16'd0, 1'b1);
        cfg_put(8'hFF, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_sample(16'd0);
        send_sample(16'hFFFF);
        program_config(hws_pkg::SHAPE_SINE, 24'h400000, 16'hFFFF, 1'b1);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd2);
        send_sample(16'd3);
        program_config(hws_pkg::SHAPE_SAWTOOTH, 24'h555555, 16'hFFFF, 1'b1);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd2);
        send_sample(16'd3);
    endtask

    task automatic random_config();
        logic [hws_pkg::STEP_BITS-1:0] st;
        logic [hws_pkg::AMP_BITS-1:0]  a;
        case ($urandom_range(7))
            0:       st = '0;
            1:       st = 24'd1;
            2:       st = 24'hFFFFFF;
            3:       st = 24'h800000;
            4:       st = 24'($urandom_range(1, 4096));
            default: st = 24'($urandom);
        endcase
        case ($urandom_range(5))
            0:       a = '0;
            1:       a = 16'hFFFF;
            default: a = 16'($urandom);
        endcase
        program_config(hws_pkg::shape_t'($urandom_range(3)), st, a, 1'($urandom_range(1)));
    endtask

    task automatic random_index(output logic [15:0] idx);
        case ($urandom_range(19))
            0:       idx = 16'd0;
            1:       idx = 16'hFFFF;
            default: idx = 16'($urandom);
        endcase
    endtask

    initial
    begin
        logic [15:0] idx;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 58 : 0;
            stall_pct <= (phase == 0) ? 58 : (phase == 1) ? 11 : 0;
            if (phase == 0)
            begin
                run_directed();
            end
            for (int chunk = 0; chunk < CHUNKS; chunk++)
            begin
                random_config();
                for (int n = 0; n < CHUNK_ITEMS; n++)
                begin
                    random_index(idx);
                    send_sample(idx);
                end
            end
        end
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Drove %0d samples across %0d register settings, all shapes, harmonics on/off",
                 sb.sample_count, settings_count);
        $display("Checked %0d results, %0d of them clamped or saturated",
                 sb.result_count, sb.clip_count);
        if (sb.error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the pipeline to drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/hws_pkg.sv
src/hws_sine_rom.sv
src/harmonic_waveform_synth_unit.sv
src/hws_checker.sv
test/tb_harmonic_waveform_synth_unit.sv
